### rtl/core/rpn_pkg.sv
// rpn_pkg: shared types, codes and defaults for the postfix expression checker
// used by rpn_fxu and rpn_expression_checker; no dependencies
package rpn_pkg;

    localparam int WORD_W          = 64;
    localparam int STACK_DEPTH_DEF = 16;
    localparam int FRAC_BITS_DEF   = 20;

    // token kinds
    localparam logic [1:0] MODE_NUM = 2'd0;
    localparam logic [1:0] MODE_OP  = 2'd1;
    localparam logic [1:0] MODE_BAD = 2'd2;
    localparam logic [1:0] MODE_END = 2'd3;

    // operators
    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    // error codes
    localparam logic [2:0] ERR_OK        = 3'd0;
    localparam logic [2:0] ERR_UNDERFLOW = 3'd1;
    localparam logic [2:0] ERR_DIVZERO   = 3'd2;
    localparam logic [2:0] ERR_BAD_TOKEN = 3'd3;
    localparam logic [2:0] ERR_DEPTH     = 3'd4;
    localparam logic [2:0] ERR_OVERFLOW  = 3'd5;

    // saturation limits
    localparam logic [WORD_W-1:0] SIGN_VAL = {1'b1, {(WORD_W-1){1'b0}}};
    localparam logic [WORD_W-1:0] MAX_VAL  = {1'b0, {(WORD_W-1){1'b1}}};

    typedef struct packed {
        logic [1:0]               mode;
        logic [1:0]               op_code;
        logic signed [WORD_W-1:0] value;
    } token_t;

    typedef struct packed {
        logic       valid_res;
        logic [2:0] error_code;
    } verdict_t;

    // request and response between the controller and the arithmetic unit
    typedef struct packed {
        logic              start;
        logic [1:0]        op;
        logic [WORD_W-1:0] opa;
        logic [WORD_W-1:0] opb;
    } fxu_req_t;

    typedef struct packed {
        logic              done;
        logic [WORD_W-1:0] result;
    } fxu_rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_B,
        ST_RD_A,
        ST_CAP_A,
        ST_RUN
    } ctl_state_t;

    typedef enum logic [3:0] {
        F_IDLE,
        F_ADDSUB,
        F_MAGA,
        F_MAGB,
        F_MUL,
        F_MRND_LO,
        F_MRND_HI,
        F_DIV,
        F_DRND1,
        F_DRND2,
        F_FIN,
        F_DONE
    } fxu_state_t;

endpackage

### rtl/core/rpn_ram.sv
// rpn_ram: generic single-write, single-read RAM with registered read data
// no dependencies
module rpn_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/core/rpn_fxu.sv
// rpn_fxu: iterative fixed-point add, subtract, multiply and divide with saturation
// built around one shared adder; depends on rpn_pkg
module rpn_fxu #(
    parameter int FRAC_BITS = rpn_pkg::FRAC_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  rpn_pkg::fxu_req_t req,
    output rpn_pkg::fxu_rsp_t rsp
);
    import rpn_pkg::*;

    localparam int NW = WORD_W + FRAC_BITS;
    localparam int CW = $clog2(NW + 1);
    localparam int SW = WORD_W + 2;
    localparam logic [WORD_W-1:0] HALF =
        (FRAC_BITS > 0) ? (WORD_W'(1) << (FRAC_BITS - 1)) : '0;

    fxu_state_t        state_reg, state_next;
    logic [1:0]        op_reg, op_next;
    logic              neg_reg, neg_next;
    logic [WORD_W-1:0] opa_reg, opa_next;
    logic [WORD_W-1:0] opb_reg, opb_next;
    logic [WORD_W-1:0] mag_a_reg, mag_a_next;
    logic [WORD_W-1:0] mag_b_reg, mag_b_next;
    logic [WORD_W-1:0] acc_reg, acc_next;
    logic [WORD_W-1:0] lo_reg, lo_next;
    logic [NW-1:0]     nsh_reg, nsh_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic              over_reg, over_next;
    logic              cy_reg, cy_next;
    logic [WORD_W-1:0] res_reg, res_next;

    logic [SW-1:0]       add_x;
    logic [SW-1:0]       add_y;
    logic                add_cin;
    logic [SW-1:0]       add_sum;
    logic [2*WORD_W-1:0] prod_sh;
    logic [WORD_W-1:0]   mag_v;
    logic [WORD_W-1:0]   sum_w;
    logic                ovf;
    logic                sat;
    logic                ge;
    logic                is_sub;

    // shared adder
    assign add_sum = add_x + add_y + SW'(add_cin);
    assign sum_w   = add_sum[WORD_W-1:0];
    assign is_sub  = (op_reg == OP_SUB);
    assign ge      = ~add_sum[SW-1];

    // adder operand selection
    always_comb
    begin
        add_x   = '0;
        add_y   = '0;
        add_cin = 1'b0;
        case (state_reg)
            F_ADDSUB:
            begin
                add_x   = {2'b00, opa_reg};
                add_y   = is_sub ? {2'b00, ~opb_reg} : {2'b00, opb_reg};
                add_cin = is_sub;
            end
            F_MAGA:
            begin
                add_y   = {2'b00, ~opa_reg};
                add_cin = 1'b1;
            end
            F_MAGB:
            begin
                add_y   = {2'b00, ~opb_reg};
                add_cin = 1'b1;
            end
            F_MUL:
            begin
                add_x = {2'b00, acc_reg};
                add_y = lo_reg[0] ? {2'b00, mag_a_reg} : '0;
            end
            F_MRND_LO:
            begin
                add_x = {2'b00, lo_reg};
                add_y = {2'b00, HALF};
            end
            F_MRND_HI:
            begin
                add_x   = {2'b00, acc_reg};
                add_cin = cy_reg;
            end
            F_DIV:
            begin
                add_x   = {1'b0, acc_reg, nsh_reg[NW-1]};
                add_y   = ~{2'b00, mag_b_reg};
                add_cin = 1'b1;
            end
            F_DRND1:
            begin
                add_x   = {1'b0, acc_reg, 1'b0};
                add_y   = ~{2'b00, mag_b_reg};
                add_cin = 1'b1;
            end
            F_DRND2:
            begin
                add_x   = {2'b00, lo_reg};
                add_cin = cy_reg;
            end
            F_FIN:
            begin
                add_y   = {2'b00, ~lo_reg};
                add_cin = 1'b1;
            end
            default:
            begin
                add_x = '0;
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (req.start)
                begin
                    if (req.op == OP_ADD || req.op == OP_SUB)
                    begin
                        state_next = F_ADDSUB;
                    end
                    else
                    begin
                        state_next = F_MAGA;
                    end
                end
            end
            F_ADDSUB:  state_next = F_DONE;
            F_MAGA:    state_next = F_MAGB;
            F_MAGB:    state_next = (op_reg == OP_MUL) ? F_MUL : F_DIV;
            F_MUL:
            begin
                if (cnt_reg == CW'(1))
                begin
                    state_next = F_MRND_LO;
                end
            end
            F_MRND_LO: state_next = F_MRND_HI;
            F_MRND_HI: state_next = F_FIN;
            F_DIV:
            begin
                if (cnt_reg == CW'(1))
                begin
                    state_next = F_DRND1;
                end
            end
            F_DRND1:   state_next = F_DRND2;
            F_DRND2:   state_next = F_FIN;
            F_FIN:     state_next = F_DONE;
            F_DONE:    state_next = F_IDLE;
            default:   state_next = F_IDLE;
        endcase
    end

    // datapath updates
    always_comb
    begin
        op_next    = op_reg;
        neg_next   = neg_reg;
        opa_next   = opa_reg;
        opb_next   = opb_reg;
        mag_a_next = mag_a_reg;
        mag_b_next = mag_b_reg;
        acc_next   = acc_reg;
        lo_next    = lo_reg;
        nsh_next   = nsh_reg;
        cnt_next   = cnt_reg;
        over_next  = over_reg;
        cy_next    = cy_reg;
        res_next   = res_reg;
        prod_sh    = '0;
        mag_v      = '0;
        ovf        = 1'b0;
        sat        = 1'b0;
        case (state_reg)
            F_IDLE:
            begin
                if (req.start)
                begin
                    op_next  = req.op;
                    opa_next = req.opa;
                    opb_next = req.opb;
                    neg_next = req.opa[WORD_W-1] ^ req.opb[WORD_W-1];
                end
            end
            // add or subtract, saturate on signed overflow
            F_ADDSUB:
            begin
                if (is_sub)
                begin
                    ovf = (opa_reg[WORD_W-1] != opb_reg[WORD_W-1])
                          && (sum_w[WORD_W-1] != opa_reg[WORD_W-1]);
                end
                else
                begin
                    ovf = (opa_reg[WORD_W-1] == opb_reg[WORD_W-1])
                          && (sum_w[WORD_W-1] != opa_reg[WORD_W-1]);
                end
                if (ovf)
                begin
                    res_next = opa_reg[WORD_W-1] ? SIGN_VAL : MAX_VAL;
                end
                else
                begin
                    res_next = sum_w;
                end
            end
            F_MAGA:
            begin
                mag_a_next = opa_reg[WORD_W-1] ? sum_w : opa_reg;
            end
            // second magnitude and loop setup
            F_MAGB:
            begin
                mag_v      = opb_reg[WORD_W-1] ? sum_w : opb_reg;
                mag_b_next = mag_v;
                acc_next   = '0;
                lo_next    = (op_reg == OP_MUL) ? mag_v : '0;
                nsh_next   = NW'(mag_a_reg) << FRAC_BITS;
                cnt_next   = (op_reg == OP_MUL) ? CW'(WORD_W) : CW'(NW);
                over_next  = 1'b0;
            end
            // shift-add multiply step
            F_MUL:
            begin
                acc_next = add_sum[WORD_W:1];
                lo_next  = {add_sum[0], lo_reg[WORD_W-1:1]};
                cnt_next = cnt_reg - CW'(1);
            end
            F_MRND_LO:
            begin
                lo_next = sum_w;
                cy_next = add_sum[WORD_W];
            end
            // carry into the high half, then drop the fraction bits
            F_MRND_HI:
            begin
                prod_sh   = {sum_w, lo_reg} >> FRAC_BITS;
                lo_next   = prod_sh[WORD_W-1:0];
                over_next = |prod_sh[2*WORD_W-1:WORD_W];
            end
            // restoring divide step, one quotient bit
            F_DIV:
            begin
                if (ge)
                begin
                    acc_next = sum_w;
                end
                else
                begin
                    acc_next = {acc_reg[WORD_W-2:0], nsh_reg[NW-1]};
                end
                lo_next   = {lo_reg[WORD_W-2:0], ge};
                over_next = over_reg | lo_reg[WORD_W-1];
                nsh_next  = nsh_reg << 1;
                cnt_next  = cnt_reg - CW'(1);
            end
            // round up when twice the remainder reaches the divisor
            F_DRND1:
            begin
                cy_next = ge;
            end
            F_DRND2:
            begin
                lo_next   = sum_w;
                over_next = over_reg | add_sum[WORD_W];
            end
            // apply sign and saturate
            F_FIN:
            begin
                if (neg_reg)
                begin
                    sat = over_reg || (lo_reg[WORD_W-1] && (|lo_reg[WORD_W-2:0]));
                    res_next = sat ? SIGN_VAL : sum_w;
                end
                else
                begin
                    sat = over_reg || lo_reg[WORD_W-1];
                    res_next = sat ? MAX_VAL : lo_reg;
                end
            end
            default:
            begin
                res_next = res_reg;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        neg_reg   <= neg_next;
        opa_reg   <= opa_next;
        opb_reg   <= opb_next;
        mag_a_reg <= mag_a_next;
        mag_b_reg <= mag_b_next;
        acc_reg   <= acc_next;
        lo_reg    <= lo_next;
        nsh_reg   <= nsh_next;
        cnt_reg   <= cnt_next;
        over_reg  <= over_next;
        cy_reg    <= cy_next;
        res_reg   <= res_next;
    end

    assign rsp.done   = (state_reg == F_DONE);
    assign rsp.result = res_reg;

endmodule

### rtl/core/rpn_expression_checker.sv
// rpn_expression_checker: postfix token evaluator with a bounded operand stack
// depends on rpn_pkg, rpn_ram and rpn_fxu
//
//   channel   signals                                   transfer
//   token     token_valid, token_stall, token_data      valid high, stall low
//   verdict   verdict_valid, verdict_stall, verdict_data valid high, stall low
//
// number, unrecognized and end tokens are taken without leaving idle; an operator is
// read through ST_RD_B, ST_RD_A and ST_CAP_A and then waits in ST_RUN for the
// shared adder of rpn_fxu, which forms one product or quotient bit per cycle
// a divide by zero is caught in ST_CAP_A and the stack is left as it was
// apart from operators, an end token is held off only while a verdict waits under stall
// reset clears depth, first error and verdict; the stack memory needs no clear
module rpn_expression_checker #(
    parameter int STACK_DEPTH = rpn_pkg::STACK_DEPTH_DEF,
    parameter int FRAC_BITS   = rpn_pkg::FRAC_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              token_valid,
    output logic              token_stall,
    input  rpn_pkg::token_t   token_data,
    output logic              verdict_valid,
    input  logic              verdict_stall,
    output rpn_pkg::verdict_t verdict_data
);
    import rpn_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int DW = $clog2(STACK_DEPTH + 1);

    ctl_state_t        state_reg, state_next;
    logic [DW-1:0]     depth_reg, depth_next;
    logic [2:0]        err_reg, err_next;
    logic [1:0]        op_reg, op_next;
    logic [WORD_W-1:0] b_reg, b_next;
    logic              verdict_valid_reg, verdict_valid_next;
    verdict_t          verdict_reg, verdict_next;

    logic              tok_acc;
    logic [DW-1:0]     depth_m1;
    logic [DW-1:0]     depth_m2;
    logic [2:0]        end_code;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic [AW-1:0]     ram_raddr;
    logic [WORD_W-1:0] ram_rdata;
    fxu_req_t          fxu_req;
    fxu_rsp_t          fxu_rsp;

    // operand stack
    rpn_ram #(
        .WIDTH (WORD_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // arithmetic unit
    rpn_fxu #(
        .FRAC_BITS (FRAC_BITS)
    ) u_fxu (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (fxu_req),
        .rsp   (fxu_rsp)
    );

    // input handshake
    assign token_stall = (state_reg != ST_IDLE)
                         || (verdict_valid_reg && verdict_stall
                             && token_data.mode == MODE_END);
    assign tok_acc     = token_valid && !token_stall;

    assign depth_m1 = depth_reg - DW'(1);
    assign depth_m2 = depth_reg - DW'(2);
    assign end_code = (err_reg != ERR_OK) ? err_reg
                      : ((depth_reg != DW'(1)) ? ERR_DEPTH : ERR_OK);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (tok_acc && token_data.mode == MODE_OP && err_reg == ERR_OK
                    && depth_reg >= DW'(2))
                begin
                    state_next = ST_RD_B;
                end
            end
            ST_RD_B:  state_next = ST_RD_A;
            ST_RD_A:  state_next = ST_CAP_A;
            ST_CAP_A:
            begin
                if (op_reg == OP_DIV && b_reg == '0)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (fxu_rsp.done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        depth_next         = depth_reg;
        err_next           = err_reg;
        op_next            = op_reg;
        b_next             = b_reg;
        verdict_valid_next = verdict_valid_reg;
        verdict_next       = verdict_reg;
        ram_we             = 1'b0;
        ram_waddr          = depth_reg[AW-1:0];
        ram_wdata          = token_data.value;
        ram_raddr          = (state_reg == ST_RD_B) ? depth_m1[AW-1:0] : depth_m2[AW-1:0];
        fxu_req            = '0;

        // verdict transfer frees the output register
        if (verdict_valid_reg && !verdict_stall)
        begin
            verdict_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (tok_acc)
                begin
                    case (token_data.mode)
                        MODE_END:
                        begin
                            verdict_valid_next      = 1'b1;
                            verdict_next.valid_res  = (end_code == ERR_OK);
                            verdict_next.error_code = end_code;
                            depth_next              = '0;
                            err_next                = ERR_OK;
                        end
                        MODE_NUM:
                        begin
                            if (err_reg == ERR_OK)
                            begin
                                if (depth_reg < DW'(STACK_DEPTH))
                                begin
                                    ram_we     = 1'b1;
                                    depth_next = depth_reg + DW'(1);
                                end
                                else
                                begin
                                    err_next = ERR_OVERFLOW;
                                end
                            end
                        end
                        MODE_OP:
                        begin
                            if (err_reg == ERR_OK)
                            begin
                                if (depth_reg < DW'(2))
                                begin
                                    err_next = ERR_UNDERFLOW;
                                end
                                else
                                begin
                                    op_next = token_data.op_code;
                                end
                            end
                        end
                        default:
                        begin
                            if (err_reg == ERR_OK)
                            begin
                                err_next = ERR_BAD_TOKEN;
                            end
                        end
                    endcase
                end
            end
            // top of stack arrives
            ST_RD_A:
            begin
                b_next = ram_rdata;
            end
            // second operand arrives, check divisor and launch
            ST_CAP_A:
            begin
                if (op_reg == OP_DIV && b_reg == '0)
                begin
                    err_next = ERR_DIVZERO;
                end
                else
                begin
                    fxu_req.start = 1'b1;
                    fxu_req.op    = op_reg;
                    fxu_req.opa   = ram_rdata;
                    fxu_req.opb   = b_reg;
                end
            end
            // pop two, push result
            ST_RUN:
            begin
                if (fxu_rsp.done)
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = depth_m2[AW-1:0];
                    ram_wdata  = fxu_rsp.result;
                    depth_next = depth_m1;
                end
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            depth_reg         <= '0;
            err_reg           <= ERR_OK;
            verdict_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            depth_reg         <= depth_next;
            err_reg           <= err_next;
            verdict_valid_reg <= verdict_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        b_reg       <= b_next;
        verdict_reg <= verdict_next;
    end

    assign verdict_valid = verdict_valid_reg;
    assign verdict_data  = verdict_reg;

`ifndef SYNTHESIS
    // stack depth stays within the memory
    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= DW'(STACK_DEPTH))
        else $error("stack depth beyond capacity");

    // an end transfer leaves an empty stack, no error and a pending verdict
    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (tok_acc && token_data.mode == MODE_END) |=>
            (depth_reg == '0 && err_reg == ERR_OK && verdict_valid_reg))
        else $error("end token did not clear state");

    // verdict flag agrees with the error code
    a_verdict_flag: assert property (@(posedge clk) disable iff (!rst_n)
        verdict_valid |-> (verdict_data.valid_res == (verdict_data.error_code == ERR_OK)))
        else $error("verdict flag and error code disagree");

    // arithmetic results only come back while the controller waits for them
    a_done_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        fxu_rsp.done |-> (state_reg == ST_RUN))
        else $error("arithmetic unit finished outside run state");
`endif

endmodule
